@@ hdl/bayer_simple_demosaic_macros.svh @@
// Assertion helpers for the demosaic block.
`ifndef BAYER_SIMPLE_DEMOSAIC_MACROS_SVH
`define BAYER_SIMPLE_DEMOSAIC_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demosaic check failed");

// Next-cycle implication, held off during reset.
`define BSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demosaic check failed");

`endif

@@ hdl/bsd_pkg.sv @@
`timescale 1ns / 1ps
package bsd_pkg;

    localparam int BSD_MAX_WIDTH  = 1024;
    localparam int BSD_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int PAT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd2;

    localparam logic [PAT_W-1:0] PAT_RESET = 2'd0;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    // Red sits at window position (ri, rj), blue diagonally across, greens on the others.
    function automatic t_rgb demosaic_window(input t_pix s00, input t_pix s01,
                                             input t_pix s10, input t_pix s11,
                                             input logic ri, input logic rj);
        t_rgb          res;
        t_pix          s [2][2];
        logic [PIX_W:0] gsum;
        s[0][0] = s00;
        s[0][1] = s01;
        s[1][0] = s10;
        s[1][1] = s11;
        res.red   = s[ri][rj];
        res.blue  = s[~ri][~rj];
        gsum      = {1'b0, s[ri][~rj]} + {1'b0, s[~ri][rj]} + {{PIX_W{1'b0}}, 1'b1};
        res.green = gsum[PIX_W:1];
        return res;
    endfunction

endpackage

@@ hdl/bsd_if.sv @@
`timescale 1ns / 1ps
interface bsd_pix_if;
    logic              valid;
    logic              ready;
    bsd_pkg::t_pix     raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface bsd_rgb_if;
    logic                         valid;
    logic                         ready;
    bsd_pkg::t_pix                red;
    bsd_pkg::t_pix                green;
    bsd_pkg::t_pix                blue;
    logic [bsd_pkg::ROW_W-1:0]    out_row;
    logic [bsd_pkg::COL_W-1:0]    out_col;
    logic                         last_of_run;

    modport source (output valid, output red, output green, output blue, output out_row,
                    output out_col, output last_of_run, input ready);
    modport sink   (input valid, input red, input green, input blue, input out_row,
                    input out_col, input last_of_run, output ready);
endinterface

interface bsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bsd_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [bsd_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hdl/bsd_line_store.sv @@
`timescale 1ns / 1ps
module bsd_line_store #(
    parameter int DEPTH = bsd_pkg::BSD_MAX_WIDTH,
    parameter int AW    = $clog2(bsd_pkg::BSD_MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  bsd_pkg::t_pix i_wdata,
    output bsd_pkg::t_pix o_rdata
);

    bsd_pkg::t_pix r_mem [DEPTH];
    bsd_pkg::t_pix r_rdata;

    // read old word, then overwrite with the new row's sample
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bayer_simple_demosaic.sv @@
`timescale 1ns / 1ps
// 2x2 Bayer demosaic over a raster stream of raw 8-bit samples.
// i_pix  : raw samples in raster order, one word per accepted handshake.
// o_rgb  : output pixels with row, column and last_of_run; pixel (y,x) is
//          built from the 2x2 window whose top-left sample is (y,x). The last
//          column and last row come out black.
// i_cfg  : register writes (0 width, 1 height, 2 pattern); always ready.
//          Width or height writes restart the frame. Write only while idle.
// Each input word gives zero to three output words; last_of_run marks the
// final one. An accepted word is registered in the input stage, alongside
// the line store read (one registered port), and then in the output holding
// register. Throughput is one input per cycle while the receiver is ready;
// the input stalls for each extra output word, which only occurs at row
// ends and in the last row.
// A stalled receiver holds the output register; the input stage keeps one
// more word before ready drops.
// Reset clears counters, window registers and configuration (width and
// height 1024, pattern RGGB); the line store is not cleared and needs no
// clearing pass, since every entry is written before it is used.
`include "bayer_simple_demosaic_macros.svh"
module bayer_simple_demosaic #(
    parameter int MAX_WIDTH  = bsd_pkg::BSD_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsd_pkg::BSD_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsd_pix_if.sink   i_pix,
    bsd_rgb_if.source o_rgb,
    bsd_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (bsd_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : bsd_pkg::RESET_WIDTH;
    localparam int RST_H = (bsd_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : bsd_pkg::RESET_HEIGHT;

    logic [CW-1:0]              r_wlast, n_wlast;
    logic [RW-1:0]              r_hlast, n_hlast;
    logic [bsd_pkg::PAT_W-1:0]  r_pattern;
    logic [CW-1:0]              r_col_cnt, n_col_cnt;
    logic [RW-1:0]              r_row_cnt, n_row_cnt;

    logic                       r_s1_valid;
    bsd_pkg::t_pix              r_s1_pix;
    logic [CW-1:0]              r_s1_col;
    logic [RW-1:0]              r_s1_row;
    logic                       r_s1_lastcol;
    logic                       r_s1_lastrow;

    bsd_pkg::t_pix              r_left;
    bsd_pkg::t_pix              r_ul;
    bsd_pkg::t_pix              up;

    logic [2:0]                 r_pend, n_pend;
    bsd_pkg::t_rgb              r_rgb;
    logic [CW-1:0]              r_o_col;
    logic [RW-1:0]              r_o_row;

    logic                       in_acc, cfg_acc, out_acc, out_free, s1_adv;
    logic [2:0]                 flags;
    logic                       ri, rj;
    bsd_pkg::t_rgb              win;
    logic [bsd_pkg::WIDTH_W-1:0]  cfg_w;
    logic [bsd_pkg::HEIGHT_W-1:0] cfg_h;

    assign cfg_acc     = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    assign out_acc  = o_rgb.valid & o_rgb.ready;
    assign out_free = ((r_pend & (r_pend - 3'd1)) == 3'd0) & (r_pend == 3'd0 | o_rgb.ready);
    assign s1_adv   = r_s1_valid & out_free;

    assign i_pix.ready = ~r_s1_valid | s1_adv;
    assign in_acc      = i_pix.valid & i_pix.ready;

    bsd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk   (i_clk),
        .i_en    (in_acc),
        .i_addr  (r_col_cnt),
        .i_wdata (i_pix.raw_pixel),
        .o_rdata (up)
    );

    // clamp geometry into range at write time
    assign cfg_w = i_cfg.wdata[bsd_pkg::WIDTH_W-1:0];
    assign cfg_h = i_cfg.wdata[bsd_pkg::HEIGHT_W-1:0];

    always_comb begin
        if (cfg_w < bsd_pkg::WIDTH_W'(2)) begin
            n_wlast = CW'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            n_wlast = CW'(MAX_WIDTH - 1);
        end else begin
            n_wlast = CW'(cfg_w - bsd_pkg::WIDTH_W'(1));
        end
        if (cfg_h < bsd_pkg::HEIGHT_W'(2)) begin
            n_hlast = RW'(1);
        end else if (32'(cfg_h) > MAX_HEIGHT) begin
            n_hlast = RW'(MAX_HEIGHT - 1);
        end else begin
            n_hlast = RW'(cfg_h - bsd_pkg::HEIGHT_W'(1));
        end
    end

    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (in_acc) begin
            if (r_col_cnt == r_wlast) begin
                n_col_cnt = '0;
                n_row_cnt = (r_row_cnt >= r_hlast) ? '0 : r_row_cnt + RW'(1);
            end else begin
                n_col_cnt = r_col_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast   <= CW'(RST_W - 1);
            r_hlast   <= RW'(RST_H - 1);
            r_pattern <= bsd_pkg::PAT_RESET;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (cfg_acc) begin
            case (i_cfg.reg_index)
                bsd_pkg::CFG_WIDTH: begin
                    r_wlast   <= n_wlast;
                    r_col_cnt <= '0;
                    r_row_cnt <= '0;
                end
                bsd_pkg::CFG_HEIGHT: begin
                    r_hlast   <= n_hlast;
                    r_col_cnt <= '0;
                    r_row_cnt <= '0;
                end
                bsd_pkg::CFG_PATTERN: begin
                    r_pattern <= i_cfg.wdata[bsd_pkg::PAT_W-1:0];
                end
                default: begin
                end
            endcase
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc | (r_s1_valid & ~s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix     <= i_pix.raw_pixel;
            r_s1_col     <= r_col_cnt;
            r_s1_row     <= r_row_cnt;
            r_s1_lastcol <= (r_col_cnt == r_wlast);
            r_s1_lastrow <= (r_row_cnt == r_hlast);
        end
    end

    // window and result flags
    assign ri  = ~r_s1_row[0] ^ r_pattern[0];
    assign rj  = ~r_s1_col[0] ^ r_pattern[1];
    assign win = bsd_pkg::demosaic_window(r_ul, up, r_left, r_s1_pix, ri, rj);

    assign flags[0] = (r_s1_row != '0) & (r_s1_col != '0);
    assign flags[1] = (r_s1_row != '0) & r_s1_lastcol;
    assign flags[2] = r_s1_lastrow;

    always_comb begin
        n_pend = r_pend;
        if (out_acc) begin
            n_pend = r_pend & (r_pend - 3'd1);
        end
        if (s1_adv) begin
            n_pend = flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_left <= '0;
            r_ul   <= '0;
        end else begin
            r_pend <= n_pend;
            if (s1_adv) begin
                r_left <= r_s1_pix;
                r_ul   <= up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rgb   <= win;
            r_o_col <= r_s1_col;
            r_o_row <= r_s1_row;
        end
    end

    // output: lowest pending result first
    assign o_rgb.valid       = |r_pend;
    assign o_rgb.red         = r_pend[0] ? r_rgb.red   : '0;
    assign o_rgb.green       = r_pend[0] ? r_rgb.green : '0;
    assign o_rgb.blue        = r_pend[0] ? r_rgb.blue  : '0;
    assign o_rgb.out_row     = bsd_pkg::ROW_W'((r_pend[0] | r_pend[1]) ? r_o_row - RW'(1)
                                                                      : r_o_row);
    assign o_rgb.out_col     = bsd_pkg::COL_W'(r_pend[0] ? r_o_col - CW'(1) : r_o_col);
    assign o_rgb.last_of_run = (r_pend & (r_pend - 3'd1)) == 3'd0;

    `BSD_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, 1'b1, r_col_cnt <= r_wlast)
    `BSD_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, out_acc & ~o_rgb.last_of_run,
                     o_rgb.valid)
    `BSD_ASSERT_NEXT(a_input_staged, i_clk, i_rst_n, in_acc, r_s1_valid)

endmodule
